FILE: hw/rtl/drkg_pkg.sv
// Package for the DES round key generator: permutation tables and helper functions.
`default_nettype none

package drkg_pkg;

    localparam int unsigned KeyBits    = 64;
    localparam int unsigned HalfBits   = 28;
    localparam int unsigned CdBits     = 56;
    localparam int unsigned SubkeyBits = 48;
    localparam int unsigned MaxRounds  = 16;

    typedef logic [HalfBits-1:0]   t_half;
    typedef logic [SubkeyBits-1:0] t_subkey;
    typedef logic [3:0]            t_round;
    typedef logic [4:0]            t_shift;

    localparam byte unsigned Pc1Tab [CdBits] = '{
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4
    };

    localparam byte unsigned Pc2Tab [SubkeyBits] = '{
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    // Total left rotation of each half after a given round, modulo 28.
    localparam t_shift RotCum [MaxRounds] = '{
        5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0
    };

    function automatic logic [CdBits-1:0] pc1(input logic [KeyBits-1:0] key);
        logic [CdBits-1:0] res;
        res = '0;
        for (int i = 0; i < CdBits; i++) begin
            res[CdBits-1-i] = key[KeyBits - int'(Pc1Tab[i])];
        end
        return res;
    endfunction

    function automatic t_subkey pc2(input logic [CdBits-1:0] cd);
        t_subkey res;
        res = '0;
        for (int i = 0; i < SubkeyBits; i++) begin
            res[SubkeyBits-1-i] = cd[CdBits - int'(Pc2Tab[i])];
        end
        return res;
    endfunction

    function automatic t_half rotl28(input t_half v, input t_shift s);
        logic [2*HalfBits-1:0] dbl;
        dbl = {v, v} >> (5'd28 - s);
        return dbl[HalfBits-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/des_round_key_generator.sv
// Top level of the DES round key generator.
`default_nettype none

// Each accepted key beat produces ROUND_COUNT round key beats (ROUND_COUNT is clamped to
// the range 1 to 16), one per cycle while the output side takes them. The 56-bit selection
// that drops the parity bits is applied at input, and each round key is formed directly
// from the stored halves by the total rotation of its round, so encrypt and decrypt order
// run at the same rate. The next key is accepted in the cycle that the last round key of
// the current one enters the output register.

module des_round_key_generator #(
    parameter int ROUND_COUNT = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [63:0] i_cipher_key,
    input  wire         i_mode,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [47:0] o_round_key,
    output logic [3:0]  o_round_index,
    output logic        o_last_key
);

    localparam int Rounds = (ROUND_COUNT < 1) ? 1 :
                            (ROUND_COUNT > 16) ? 16 : ROUND_COUNT;
    localparam drkg_pkg::t_round LastRound = 4'(Rounds - 1);

    drkg_pkg::t_half  r_c;
    drkg_pkg::t_half  r_d;
    logic             r_rev;
    logic             r_busy;
    drkg_pkg::t_round r_cnt;

    logic [55:0]       cd_in;
    logic              step;
    logic              done_step;
    logic              accept;
    drkg_pkg::t_round  round_idx;
    drkg_pkg::t_subkey subkey;

    assign cd_in      = drkg_pkg::pc1(i_cipher_key);
    assign step       = r_busy && (!o_out_valid || i_out_ready);
    assign done_step  = step && (r_cnt == LastRound);
    assign o_in_ready = !r_busy || done_step;
    assign accept     = i_in_valid && o_in_ready;
    assign round_idx  = r_rev ? (LastRound - r_cnt) : r_cnt;

    drkg_subkey u_subkey (
        .i_c      (r_c),
        .i_d      (r_d),
        .i_round  (round_idx),
        .o_subkey (subkey)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_rev       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rev  <= i_mode;
            end else if (done_step) begin
                r_busy <= 1'b0;
            end else if (step) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (step) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c <= cd_in[55:28];
            r_d <= cd_in[27:0];
        end
        if (step) begin
            o_round_key   <= subkey;
            o_round_index <= round_idx;
            o_last_key    <= (r_cnt == LastRound);
        end
    end

`ifndef ASSERT_OFF
    // A new key is taken only when no run is in progress or the current one is finishing.
    a_accept_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_busy || (r_cnt == LastRound)))
        else $error("key beat accepted in the middle of a run");

    // The round counter never passes the last round of a run.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= LastRound))
        else $error("round counter out of range");

    // A run that has not reached its last round stays busy.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !done_step) |=> r_busy)
        else $error("run ended before its last round key");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/drkg_subkey.sv
// Subkey logic: rotates both halves to a given round and makes the 48-bit round key selection.
`default_nettype none

module drkg_subkey (
    input  wire drkg_pkg::t_half   i_c,
    input  wire drkg_pkg::t_half   i_d,
    input  wire drkg_pkg::t_round  i_round,
    output drkg_pkg::t_subkey      o_subkey
);

    drkg_pkg::t_shift shift;
    drkg_pkg::t_half  c_rot;
    drkg_pkg::t_half  d_rot;

    assign shift    = drkg_pkg::RotCum[i_round];
    assign c_rot    = drkg_pkg::rotl28(i_c, shift);
    assign d_rot    = drkg_pkg::rotl28(i_d, shift);
    assign o_subkey = drkg_pkg::pc2({c_rot, d_rot});

endmodule

`default_nettype wire
